// ===== rtl/core/lge_pkg.sv =====
// Shared types and constants for the life grid engine.
package lge_pkg;

   localparam int DefGridWidth  = 64;
   localparam int DefGridHeight = 32;
   localparam int ColW = 7;
   localparam int RowW = 6;
   localparam int PopW = 12;
   localparam int GenW = 32;

   localparam logic [2:0] KIND_WRITE  = 3'd0;
   localparam logic [2:0] KIND_TOGGLE = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_STEP   = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]      kind;
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            alive_in;
   } req_type;

   typedef struct packed {
      logic            cell_value;
      logic [PopW-1:0] population;
      logic [GenW-1:0] generation;
   } rsp_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic capture;     // latch request, reset scan position
      logic cell_rd;     // read addressed cell
      logic cell_wr;     // write/toggle addressed cell, latch cell value
      logic scan_rd;     // read current scan cell
      logic scan_wr;     // write next value of scan cell
      logic scan_adv;    // advance scan position
      logic copy_rd;     // read next array at scan position
      logic copy_wr;     // write grid from next array
      logic clear_wr;    // write zero at scan position
      logic finish;      // commit counts, drive response
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       scan_last;
   } sts_type;

endpackage

// ===== rtl/core/lge_ctrl.sv =====
// Sequencer for cell accesses, generation sweeps and clear sweeps.
module lge_ctrl import lge_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_CRD   = 10'b0000000100,
      S_CWR   = 10'b0000001000,
      S_SRD   = 10'b0000010000,
      S_SWR   = 10'b0000100000,
      S_CPRD  = 10'b0001000000,
      S_CPWR  = 10'b0010000000,
      S_CLR   = 10'b0100000000,
      S_INIT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.kind)
               KIND_WRITE, KIND_TOGGLE, KIND_READ: state_in = S_CRD;
               KIND_STEP:  state_in = S_SRD;
               KIND_CLEAR: state_in = S_CLR;
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_CRD: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_CWR;
         end
         S_CWR: begin
            cmd.cell_wr = 1'b1;
            cmd.finish  = 1'b1;
            state_in    = S_IDLE;
         end
         S_SRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SWR;
         end
         S_SWR: begin
            cmd.scan_wr = 1'b1;
            cmd.scan_adv = 1'b1;
            state_in = sts.scan_last ? S_CPRD : S_SRD;
         end
         S_CPRD: begin
            cmd.copy_rd = 1'b1;
            state_in    = S_CPWR;
         end
         S_CPWR: begin
            cmd.copy_wr  = 1'b1;
            cmd.scan_adv = 1'b1;
            if (sts.scan_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_CPRD;
            end
         end
         S_CLR: begin
            cmd.clear_wr = 1'b1;
            cmd.scan_adv = 1'b1;
            if (sts.scan_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         // Wipe the grid row by row after reset; no response.
         S_INIT: begin
            cmd.clear_wr = 1'b1;
            cmd.scan_adv = 1'b1;
            if (sts.scan_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/lge_datapath.sv =====
// Grid memory, scan counters, neighbor gathering and population/generation counts.
module lge_datapath import lge_pkg::*; #(
   parameter int GRID_WIDTH  = DefGridWidth,
   parameter int GRID_HEIGHT = DefGridHeight
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    torus_en,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
   localparam int AddrW = $clog2(Cells);
   localparam int CW    = $clog2(GRID_WIDTH);
   localparam int RW    = $clog2(GRID_HEIGHT);

   // Reciprocal constants for folding off-grid read coordinates.
   localparam int ColShift = 14;
   localparam int RowShift = 12;
   localparam int ColRecip = ((1 << ColShift) + GRID_WIDTH - 1) / GRID_WIDTH;
   localparam int RowRecip = ((1 << RowShift) + GRID_HEIGHT - 1) / GRID_HEIGHT;

   // Grid stored as one row word per address; row count small, width up to 128.
   logic [GRID_WIDTH-1:0] grid_mem [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] next_mem [GRID_HEIGHT];

   req_type         req_ff;
   logic [CW-1:0]   sc_ff;   // scan column
   logic [RW-1:0]   sr_ff;   // scan row
   logic [PopW-1:0] live_ff, pop_ff;
   logic [GenW-1:0] gen_ff;
   logic            cell_ff;
   logic            wrap_ff;

   // Row-window registers for the sweep: rows above, at, below the scan row.
   logic [GRID_WIDTH-1:0] up_ff, mid_ff, dn_ff, cp_ff;
   logic [GRID_WIDTH-1:0] rd_word_ff;

   logic          in_grid;
   logic [CW-1:0] a_col;
   logic [RW-1:0] a_row;
   logic [RW-1:0] r_up, r_dn;
   logic          up_ok, dn_ok;

   logic [ColShift+ColW-1:0] col_prod;
   logic [RowShift+RowW-1:0] row_prod;
   logic [ColW-1:0]          col_quo, col_rem;
   logic [RowW-1:0]          row_quo, row_rem;

   assign in_grid = ({1'b0, req_ff.col} < (ColW+1)'(GRID_WIDTH)) &&
                    ({1'b0, req_ff.row} < (RowW+1)'(GRID_HEIGHT));

   // Wrapped address for reads: quotient by reciprocal multiply, exact for
   // 7-bit columns and 6-bit rows, then subtract quotient times grid size.
   always_comb begin
      col_prod = (ColShift+ColW)'(req_ff.col) * (ColShift+ColW)'(ColRecip);
      row_prod = (RowShift+RowW)'(req_ff.row) * (RowShift+RowW)'(RowRecip);
      col_quo  = col_prod[ColShift +: ColW];
      row_quo  = row_prod[RowShift +: RowW];
      col_rem  = ColW'({1'b0, req_ff.col} -
                       (ColW+1)'(col_quo) * (ColW+1)'(GRID_WIDTH));
      row_rem  = RowW'({1'b0, req_ff.row} -
                       (RowW+1)'(row_quo) * (RowW+1)'(GRID_HEIGHT));
      a_col    = col_rem[CW-1:0];
      a_row    = row_rem[RW-1:0];
   end

   always_comb begin
      up_ok = (sr_ff != '0) || wrap_ff;
      dn_ok = (sr_ff != RW'(GRID_HEIGHT - 1)) || wrap_ff;
      r_up  = (sr_ff == '0) ? RW'(GRID_HEIGHT - 1) : sr_ff - 1'b1;
      r_dn  = (sr_ff == RW'(GRID_HEIGHT - 1)) ? '0 : sr_ff + 1'b1;
   end

   assign sts.kind      = req_ff.kind;
   assign sts.scan_last = cmd.clear_wr || cmd.copy_wr ?
                          (sr_ff == RW'(GRID_HEIGHT - 1)) :
                          (sr_ff == RW'(GRID_HEIGHT - 1)) && (sc_ff == CW'(GRID_WIDTH - 1));

   // Neighbor evaluation at the scan cell from the row window.
   logic [CW-1:0] c_l, c_r;
   logic          l_ok, r_ok;
   logic [3:0]    ncount;
   logic          self, nv;
   always_comb begin
      l_ok = (sc_ff != '0) || wrap_ff;
      r_ok = (sc_ff != CW'(GRID_WIDTH - 1)) || wrap_ff;
      c_l  = (sc_ff == '0) ? CW'(GRID_WIDTH - 1) : sc_ff - 1'b1;
      c_r  = (sc_ff == CW'(GRID_WIDTH - 1)) ? '0 : sc_ff + 1'b1;
      self = mid_ff[sc_ff];
      ncount = 4'((up_ok & l_ok & up_ff[c_l])) + 4'((up_ok & up_ff[sc_ff]))
             + 4'((up_ok & r_ok & up_ff[c_r])) + 4'((l_ok & mid_ff[c_l]))
             + 4'((r_ok & mid_ff[c_r])) + 4'((dn_ok & l_ok & dn_ff[c_l]))
             + 4'((dn_ok & dn_ff[sc_ff])) + 4'((dn_ok & r_ok & dn_ff[c_r]));
      nv = (ncount == 4'd3) || (self && ncount == 4'd2);
   end

   // Row window loads: fetch three rows at the start of each row (scan_rd, col 0).
   // Memory reads are registered; the window is loaded from three reads in one
   // cycle of separate copies would cost ports, so one row mem is read per cycle
   // and a small row-fetch sequence is folded into scan_rd at col 0.
   logic [1:0] fetch_ff;
   logic       row_ready;
   assign row_ready = (fetch_ff == 2'd3);

   logic [GRID_WIDTH-1:0] nrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         gen_ff    <= '0;
         rsp_valid <= 1'b0;
         wrap_ff   <= 1'b0;
         fetch_ff  <= '0;
         sc_ff     <= '0;
         sr_ff     <= '0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.capture) begin
            req_ff   <= req;
            sc_ff    <= '0;
            sr_ff    <= '0;
            pop_ff   <= '0;
            cell_ff  <= 1'b0;
            wrap_ff  <= torus_en;
            fetch_ff <= '0;
         end
         if (cmd.cell_rd) begin
            rd_word_ff <= grid_mem[in_grid ? req_ff.row[RW-1:0] : a_row];
         end
         if (cmd.cell_wr) begin
            case (req_ff.kind)
               KIND_WRITE: if (in_grid) begin
                  cell_ff <= req_ff.alive_in;
                  if (rd_word_ff[req_ff.col[CW-1:0]] != req_ff.alive_in)
                     live_ff <= req_ff.alive_in ? live_ff + 1'b1 : live_ff - 1'b1;
               end
               KIND_TOGGLE: if (in_grid) begin
                  cell_ff <= ~rd_word_ff[req_ff.col[CW-1:0]];
                  live_ff <= rd_word_ff[req_ff.col[CW-1:0]] ? live_ff - 1'b1
                                                            : live_ff + 1'b1;
               end
               KIND_READ: begin
                  if (wrap_ff)      cell_ff <= rd_word_ff[a_col];
                  else if (in_grid) cell_ff <= rd_word_ff[req_ff.col[CW-1:0]];
               end
               default: cell_ff <= 1'b0;
            endcase
         end
         // Sweep: scan_rd at column 0 fetches the three rows over three visits.
         if (cmd.scan_rd && sc_ff == '0 && !row_ready) begin
            fetch_ff <= fetch_ff + 1'b1;
            case (fetch_ff)
               2'd0:    up_ff  <= grid_mem[r_up];
               2'd1:    mid_ff <= grid_mem[sr_ff];
               default: dn_ff  <= grid_mem[r_dn];
            endcase
         end
         if (cmd.scan_wr && row_ready) begin
            nrow_ff[sc_ff] <= nv;
            pop_ff <= pop_ff + PopW'(nv);
            if (sc_ff == CW'(GRID_WIDTH - 1)) begin
               next_mem[sr_ff] <= {nv, nrow_ff[GRID_WIDTH-2:0]};
               fetch_ff <= '0;
            end
         end
         if (cmd.scan_adv && (cmd.copy_wr || cmd.clear_wr)) begin
            sc_ff <= '0;
            sr_ff <= (sr_ff == RW'(GRID_HEIGHT - 1)) ? '0 : sr_ff + 1'b1;
         end else if (cmd.scan_adv && row_ready) begin
            if (sc_ff == CW'(GRID_WIDTH - 1)) begin
               sc_ff <= '0;
               sr_ff <= (sr_ff == RW'(GRID_HEIGHT - 1)) ? '0 : sr_ff + 1'b1;
            end else begin
               sc_ff <= sc_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            case (req_ff.kind)
               KIND_STEP: begin
                  live_ff <= pop_ff;
                  gen_ff  <= gen_ff + 1'b1;
               end
               KIND_CLEAR: begin
                  live_ff <= '0;
                  gen_ff  <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // Memory writes and the copy-back read.
   always_ff @(posedge clock) begin
      if (cmd.copy_rd) cp_ff <= next_mem[sr_ff];
      if (cmd.copy_wr) grid_mem[sr_ff] <= cp_ff;
      if (cmd.clear_wr) grid_mem[sr_ff] <= '0;
      if (cmd.cell_wr && in_grid &&
          (req_ff.kind == KIND_WRITE || req_ff.kind == KIND_TOGGLE)) begin
         grid_mem[req_ff.row[RW-1:0]] <= rd_word_ff ^
            ((GRID_WIDTH'(1) << req_ff.col[CW-1:0]) &
             ((req_ff.kind == KIND_TOGGLE) ? '1 :
              ((rd_word_ff[req_ff.col[CW-1:0]] != req_ff.alive_in) ? '1 : '0)));
      end
   end

   always_comb begin
      rsp.cell_value = (req_ff.kind == KIND_STEP || req_ff.kind == KIND_CLEAR) ? 1'b0 : cell_ff;
      rsp.population = live_ff;
      rsp.generation = gen_ff;
   end

endmodule

// ===== rtl/core/life_grid_engine.sv =====
// Top level of the life grid engine: controller, datapath and edge-mode register.
//
// Usage:
//   Request channel: drive req_item with start high while busy is low; the
//   request is taken at that edge. Kinds: write, toggle, read, step, clear.
//   Response channel: rsp_valid pulses for one cycle with cell_value,
//   population and generation; the receiver cannot stall and must take it.
//   Configuration: csr_wr_en/csr_wr_data set the edge mode; write only when idle.
// Sequencing:
//   Cell write, toggle and read: decode, cell read, then cell write with the
//   response registered behind it; a new request is taken only once busy is low.
//   Step: each row costs two row-fetch pairs plus one read/evaluate pair per
//   cell (the third fetch overlaps the first cell); after the last row, each row
//   is copied back from the next-state memory by a read and a write.
//   Clear: the grid is wiped row by row, and counts return to zero.
//   Unused kinds answer from the decode state with counts unchanged.
// Reset:
//   Synchronous reset zeroes counts and the edge mode; busy then stays high
//   while the grid is wiped row by row.
module life_grid_engine import lge_pkg::*; #(
   parameter int GRID_WIDTH  = DefGridWidth,
   parameter int GRID_HEIGHT = DefGridHeight
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   cmd_type cmd;
   sts_type sts;
   logic    wrap_ff;

   // Hold the edge mode until rewritten.
   always_ff @(posedge clock) begin
      if (reset)          wrap_ff <= 1'b0;
      else if (csr_wr_en) wrap_ff <= csr_wr_data;
   end

   lge_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   lge_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .torus_en   (wrap_ff),
      .req        (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_item)
   );

endmodule

// ===== rtl/core/lge_checker.sv =====
// Port-level checker for the life grid engine, bound to the top level.
module lge_checker import lge_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_item)) else $error("unknown request taken");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_item)) else $error("unknown response fields");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with response out");

endmodule

bind life_grid_engine lge_checker u_lge_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
